// File: hdl/ccrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrc_pkg
// Shared types, register indexes and bit helpers for the configurable CRC
// engine: width decode, bit mirroring and one LFSR shift step.
// ----------------------------------------------------------------------------
package ccrc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_CRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_DATA_WIDTH = 3'd1;
    localparam logic [2:0] REG_POLYNOMIAL = 3'd2;
    localparam logic [2:0] REG_INIT_VALUE = 3'd3;
    localparam logic [2:0] REG_REFLECTED  = 3'd4;
    localparam logic [2:0] REG_FINAL_XOR  = 3'd5;

    // Width codes
    localparam logic [1:0] WCODE_8  = 2'd0;
    localparam logic [1:0] WCODE_16 = 2'd1;
    localparam logic [1:0] WCODE_32 = 2'd2;

    // Reset values
    localparam logic [31:0] POLY_RESET = 32'h04C1_1DB7;
    localparam logic [31:0] ONES_32    = 32'hFFFF_FFFF;

    typedef logic [31:0] col_t;
    typedef col_t [31:0] mat_t;

    typedef struct packed {
        logic [1:0]  crc_width;
        logic [1:0]  data_width;
        logic [31:0] polynomial;
        logic [31:0] init_value;
        logic        reflected;
        logic [31:0] final_xor;
    } ccrc_cfg_t;

    // Matrix builder sequencer
    typedef enum logic [1:0] {
        BLD_LOAD,
        BLD_STEP,
        BLD_DONE
    } build_state_t;

    // Mask for a width code; code 3 acts as 32 bits
    function automatic logic [31:0] width_mask(input logic [1:0] code);
        logic [31:0] m;
        case (code)
            WCODE_8:  m = 32'h0000_00FF;
            WCODE_16: m = 32'h0000_FFFF;
            default:  m = ONES_32;
        endcase
        return m;
    endfunction

    // Index of the top bit for a width code
    function automatic logic [4:0] top_index(input logic [1:0] code);
        logic [4:0] t;
        case (code)
            WCODE_8:  t = 5'd7;
            WCODE_16: t = 5'd15;
            default:  t = 5'd31;
        endcase
        return t;
    endfunction

    // Bit-mirror the low bits of v over the width given by code
    function automatic logic [31:0] mirror_w(input logic [31:0] v, input logic [1:0] code);
        logic [31:0] rev;
        logic [31:0] r;
        for (int i = 0; i < 32; i++)
        begin
            rev[i] = v[31-i];
        end
        case (code)
            WCODE_8:  r = {24'd0, rev[31:24]};
            WCODE_16: r = {16'd0, rev[31:16]};
            default:  r = rev;
        endcase
        return r;
    endfunction

    // One shift of the CRC register with one input bit
    function automatic logic [31:0] crc_step(
        input logic [31:0] col,
        input logic        din,
        input logic [31:0] poly_n,
        input logic [31:0] poly_r,
        input logic        refl,
        input logic [31:0] mask,
        input logic [4:0]  top
    );
        logic [31:0] r;
        logic        fb;
        if (refl)
        begin
            fb = col[0] ^ din;
            r  = (col >> 1) ^ (fb ? poly_r : 32'd0);
        end
        else
        begin
            fb = col[top] ^ din;
            r  = ((col << 1) & mask) ^ (fb ? poly_n : 32'd0);
        end
        return r;
    endfunction

endpackage

// File: hdl/ccrc_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrc_matrix
// Builds the per-word update matrices of the CRC: one column per register bit
// and one per data bit, stepped together through one bit shift per cycle.
// ----------------------------------------------------------------------------
module ccrc_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               restart,
    input  ccrc_pkg::ccrc_cfg_t cfg,
    output ccrc_pkg::mat_t     a_cols,
    output ccrc_pkg::mat_t     b_cols,
    output logic               ready
);
    import ccrc_pkg::*;

    build_state_t state_reg, state_next;
    logic [4:0]   cnt_reg, cnt_next;
    mat_t         a_reg, b_reg;

    logic [31:0] mask;
    logic [4:0]  top;
    logic [4:0]  dw_last;
    logic [31:0] poly_n;
    logic [31:0] poly_r;

    // Decoded configuration
    always_comb
    begin
        mask    = width_mask(cfg.crc_width);
        top     = top_index(cfg.crc_width);
        dw_last = top_index(cfg.data_width);
        poly_n  = cfg.polynomial & mask;
        poly_r  = mirror_w(cfg.polynomial, cfg.crc_width);
    end

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            BLD_LOAD:
            begin
                cnt_next   = 5'd0;
                state_next = BLD_STEP;
            end
            BLD_STEP:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == dw_last)
                begin
                    state_next = BLD_DONE;
                end
            end
            BLD_DONE:
            begin
                state_next = BLD_DONE;
            end
            default:
            begin
                state_next = BLD_LOAD;
            end
        endcase
        if (restart)
        begin
            state_next = BLD_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BLD_LOAD;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Column lanes: load unit vectors, then one shift per cycle
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 32; j++)
        begin
            if (state_reg == BLD_LOAD)
            begin
                a_reg[j] <= (5'(j) <= top) ? (32'd1 << j) : 32'd0;
                b_reg[j] <= 32'd0;
            end
            else if (state_reg == BLD_STEP)
            begin
                a_reg[j] <= crc_step(a_reg[j], 1'b0, poly_n, poly_r,
                                     cfg.reflected, mask, top);
                b_reg[j] <= crc_step(b_reg[j],
                                     cfg.reflected ? (cnt_reg == 5'(j))
                                                   : (5'(j) == dw_last - cnt_reg),
                                     poly_n, poly_r, cfg.reflected, mask, top);
            end
        end
    end

    assign a_cols = a_reg;
    assign b_cols = b_reg;
    assign ready  = (state_reg == BLD_DONE);

    // Checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BLD_STEP) |-> (cnt_reg <= dw_last))
        else $error("build step count past data width");

    a_restart_load: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (state_reg == BLD_LOAD))
        else $error("restart did not reload lanes");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == BLD_DONE) && !restart) |=> (state_reg == BLD_DONE))
        else $error("finished matrices dropped without restart");

endmodule

// File: hdl/configurable_crc_engine_unit.sv
`timescale 1ns / 1ps
// Each result is registered twice on its way out: input register, then result register.
// One word per cycle unless m_tready or a rebuild stalls; each update is one XOR matrix pass.
// After reset and after every configuration write the update matrices are rebuilt,
// one bit shift per cycle: s_tready stays low until the rebuild is done.
// Reset is asynchronous, active low; configuration returns to its reset values and
// the running CRC register clears to zero.
// ----------------------------------------------------------------------------
// configurable_crc_engine_unit
// Rocksoft-style CRC of width 8, 16 or 32 over 8, 16 or 32 bit words, one
// running result per word.
// ----------------------------------------------------------------------------
module configurable_crc_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] data_word
    input  logic        s_tuser,   // [0] first
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] crc_value
    // Configuration writes
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import ccrc_pkg::*;

    ccrc_cfg_t   cfg_reg;
    mat_t        a_cols, b_cols;
    logic        mtx_ready;

    logic        s1_valid_reg;
    logic [31:0] s1_data_reg;
    logic        s1_first_reg;
    logic [31:0] crc_state_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic        advance;
    logic        s1_load;
    logic [31:0] mask;
    logic [31:0] init_start;
    logic [31:0] crc_start;
    logic [31:0] crc_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_width  <= WCODE_32;
            cfg_reg.data_width <= WCODE_8;
            cfg_reg.polynomial <= POLY_RESET;
            cfg_reg.init_value <= ONES_32;
            cfg_reg.reflected  <= 1'b1;
            cfg_reg.final_xor  <= ONES_32;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_CRC_WIDTH:  cfg_reg.crc_width  <= cfg_wdata[1:0];
                REG_DATA_WIDTH: cfg_reg.data_width <= cfg_wdata[1:0];
                REG_POLYNOMIAL: cfg_reg.polynomial <= cfg_wdata;
                REG_INIT_VALUE: cfg_reg.init_value <= cfg_wdata;
                REG_REFLECTED:  cfg_reg.reflected  <= cfg_wdata[0];
                REG_FINAL_XOR:  cfg_reg.final_xor  <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    ccrc_matrix u_matrix (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_wr_en),
        .cfg     (cfg_reg),
        .a_cols  (a_cols),
        .b_cols  (b_cols),
        .ready   (mtx_ready)
    );

    // Flow control: input stage moves on when the result register is free
    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = mtx_ready && (!s1_valid_reg || advance);
    assign s1_load  = s_tvalid && s_tready;

    // Start value and one matrix pass over register and data bits
    always_comb
    begin
        mask       = width_mask(cfg_reg.crc_width);
        init_start = cfg_reg.reflected ? mirror_w(cfg_reg.init_value, cfg_reg.crc_width)
                                       : (cfg_reg.init_value & mask);
        crc_start  = s1_first_reg ? init_start : (crc_state_reg & mask);
        crc_next   = 32'd0;
        for (int j = 0; j < 32; j++)
        begin
            crc_next = crc_next ^ ({32{crc_start[j]}} & a_cols[j])
                                ^ ({32{s1_data_reg[j]}} & b_cols[j]);
        end
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_data_reg  <= s_tdata;
            s1_first_reg <= s_tuser;
        end
    end

    // Running CRC register and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_state_reg <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                crc_state_reg <= crc_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= (crc_next ^ cfg_reg.final_xor) & mask;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Checks
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !s_tready)
        else $error("input accepted while matrices rebuild");

    a_ready_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> mtx_ready)
        else $error("input ready without valid matrices");

    a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_tready) |=> (s1_valid_reg && out_valid_reg))
        else $error("pending word lost under back-pressure");

    a_state_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (m_tvalid && (crc_state_reg == $past(crc_next))))
        else $error("running CRC not updated with result");

endmodule

// File: dv/configurable_crc_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// configurable_crc_engine_unit_tb
// Self-checking bench for the configurable CRC engine. A short directed pass
// covers the reset setting, the case with no message start since reset, data
// wider than the CRC, a width change mid-message and the width code that
// aliases to 32 bits. Random settings and messages follow, with random gaps
// on the input side and random stalls on the result side. Every accepted
// word is run through a bit-serial CRC model and each result is compared in
// order.
// ----------------------------------------------------------------------------
import ccrc_pkg::*;

// Bit-serial CRC model plus the queue of CRC values still owed by the block
class crc_scoreboard;
    logic [1:0]  crc_code;
    logic [1:0]  data_code;
    logic [31:0] poly;
    logic [31:0] init;
    logic        refl;
    logic [31:0] xor_out;
    logic [31:0] crc_reg;

    logic [31:0] expected_crc[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
        crc_code     = WCODE_32;
        data_code    = WCODE_8;
        poly         = POLY_RESET;
        init         = ONES_32;
        refl         = 1'b1;
        xor_out      = ONES_32;
        crc_reg      = '0;
        mismatches   = 0;
        results_seen = 0;
    endfunction

    function int unsigned code_to_bits(logic [1:0] code);
        case (code)
            WCODE_8:  return 8;
            WCODE_16: return 16;
            default:  return 32;
        endcase
    endfunction

    function logic [31:0] reverse_bits(logic [31:0] v, int unsigned n);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < n; i++)
            r = (r << 1) | {31'd0, v[i]};
        return r;
    endfunction

    // Register write as seen by the block; spare indexes are ignored
    function void apply_write(logic [2:0] idx, logic [31:0] value);
        case (idx)
            REG_CRC_WIDTH:  crc_code  = value[1:0];
            REG_DATA_WIDTH: data_code = value[1:0];
            REG_POLYNOMIAL: poly      = value;
            REG_INIT_VALUE: init      = value;
            REG_REFLECTED:  refl      = value[0];
            REG_FINAL_XOR:  xor_out   = value;
            default: ;
        endcase
    endfunction

    // Accepted word: advance the running CRC and queue the output it owes
    function void note_word(logic [31:0] word, logic first);
        int unsigned cw;
        int unsigned dw;
        logic [31:0] mask;
        logic [31:0] crc;
        logic [31:0] p;
        logic        fb;
        cw   = code_to_bits(crc_code);
        dw   = code_to_bits(data_code);
        mask = (cw == 32) ? ONES_32 : ((32'd1 << cw) - 32'd1);
        if (first)
            crc = refl ? reverse_bits(init, cw) : (init & mask);
        else
            crc = crc_reg & mask;
        if (refl)
        begin
            // LSB-first with mirrored generator
            p = reverse_bits(poly, cw);
            for (int i = 0; i < dw; i++)
            begin
                fb  = crc[0] ^ word[i];
                crc = crc >> 1;
                if (fb)
                    crc ^= p;
            end
        end
        else
        begin
            // MSB-first, every data bit in order even when wider than the CRC
            p = poly & mask;
            for (int i = 0; i < dw; i++)
            begin
                fb  = crc[cw-1] ^ word[dw-1-i];
                crc = (crc << 1) & mask;
                if (fb)
                    crc ^= p;
            end
        end
        crc     = crc & mask;
        crc_reg = crc;
        expected_crc.push_back((crc ^ xor_out) & mask);
    endfunction

    // Result transfer: compare with the oldest queued CRC
    function void check_crc(logic [31:0] actual);
        logic [31:0] want;
        results_seen++;
        if (expected_crc.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected result crc=%08h", $time, actual);
            return;
        end
        want = expected_crc.pop_front();
        if (actual !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] crc mismatch: expected %08h, got %08h",
                         $time, want, actual);
        end
    endfunction
endclass

module configurable_crc_engine_unit_tb;

    localparam logic [1:0] WCODE_ALIAS = 2'd3;   // decodes as 32 bits
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;
    localparam int unsigned RANDOM_WORDS = 1750;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    crc_scoreboard sb = new();

    int unsigned words_sent = 0;
    int unsigned reg_writes = 0;
    int unsigned settings   = 0;
    bit          no_idle    = 1'b0;

    configurable_crc_engine_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // Transfer monitor
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_word(s_tdata, s_tuser);
        if (rst_n && m_tvalid && m_tready)
            sb.check_crc(m_tdata);
    end

    // Result side: random stall before each transfer
    initial
    begin : result_sink
        int unsigned stall;
        m_tready <= 1'b0;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Hang guard
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d words sent, %0d results seen",
                 words_sent, sb.results_seen);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_word(input logic [31:0] word, input logic first);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= first;
        do @(posedge clk); while (!s_tready);
        words_sent++;
    endtask

    // Stop sending and wait until every result is back and the pipe is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.results_seen < words_sent)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.apply_write(idx, value);
        reg_writes++;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_all(input logic [1:0] cw, input logic [1:0] dw,
                           input logic [31:0] p, input logic [31:0] iv,
                           input logic rf, input logic [31:0] fx);
        write_reg(REG_CRC_WIDTH, {30'd0, cw});
        write_reg(REG_DATA_WIDTH, {30'd0, dw});
        write_reg(REG_POLYNOMIAL, p);
        write_reg(REG_INIT_VALUE, iv);
        write_reg(REG_REFLECTED, {31'd0, rf});
        write_reg(REG_FINAL_XOR, fx);
        settings++;
    endtask

    function automatic logic [31:0] pick_value(input bit as_poly);
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return ONES_32;
            2:       return as_poly ? POLY_RESET : 32'h8000_0001;
            3:       return as_poly ? 32'h0000_1021 : 32'h0000_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Random setting; width codes carry junk in the upper bits at times
    task automatic random_config(input bit write_all);
        logic [31:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? ($urandom & ~32'h3) : 32'd0;
        if (write_all || $urandom_range(0, 1))
            write_reg(REG_CRC_WIDTH, junk | $urandom_range(0, 3));
        if (write_all || $urandom_range(0, 1))
            write_reg(REG_DATA_WIDTH, junk | $urandom_range(0, 3));
        if (write_all || $urandom_range(0, 1))
            write_reg(REG_POLYNOMIAL, pick_value(1'b1));
        if (write_all || $urandom_range(0, 1))
            write_reg(REG_INIT_VALUE, pick_value(1'b0));
        if (write_all || $urandom_range(0, 1))
            write_reg(REG_REFLECTED, junk | $urandom_range(0, 1));
        if (write_all || $urandom_range(0, 1))
            write_reg(REG_FINAL_XOR, pick_value(1'b0));
        settings++;
    endtask

    // Stimulus
    initial
    begin : main
        int unsigned target;
        int unsigned phase_left;
        int unsigned msg_len;
        logic [31:0] word;
        bit          paused;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting; the first two words run before any message start
        send_word(ONES_32, 1'b0);
        send_word(32'd0, 1'b0);
        send_word(32'h0000_0031, 1'b1);
        send_word(32'hFFFF_FF32, 1'b0);
        drain();

        // CRC-8 normal over 32-bit words (data wider than the CRC)
        set_all(WCODE_8, WCODE_32, 32'h0000_0007, 32'd0, 1'b0, 32'd0);
        send_word(32'h1234_5678, 1'b1);
        send_word(ONES_32, 1'b0);
        send_word(32'h8000_0001, 1'b0);
        drain();

        // Same widths reflected
        write_reg(REG_REFLECTED, 32'd1);
        send_word(32'hDEAD_BEEF, 1'b1);
        send_word(32'h0000_0001, 1'b0);
        drain();

        // Width changes in the middle of a message
        set_all(WCODE_16, WCODE_16, 32'h0000_1021, 32'h0000_FFFF, 1'b0, 32'd0);
        send_word(32'hFFFF_FFFF, 1'b1);
        drain();
        write_reg(REG_CRC_WIDTH, {30'd0, WCODE_32});
        send_word(32'h0000_A5A5, 1'b0);
        drain();
        write_reg(REG_CRC_WIDTH, {30'd0, WCODE_8});
        send_word(32'h0000_5A5A, 1'b0);
        drain();

        // Width code that decodes as 32 bits, all-ones generator
        set_all(WCODE_ALIAS, WCODE_ALIAS, ONES_32, 32'd0, 1'b1, ONES_32);
        send_word(ONES_32, 1'b1);
        send_word(32'd0, 1'b0);
        drain();

        // Zero generator, normal mode; writes to spare indexes change nothing
        set_all(WCODE_32, WCODE_8, 32'd0, ONES_32, 1'b0, 32'hA5A5_5A5A);
        write_reg(REG_SPARE_6, $urandom);
        write_reg(REG_SPARE_7, $urandom);
        send_word(32'h0000_00AA, 1'b1);
        send_word(32'hFFFF_FF55, 1'b0);
        drain();

        // Random settings, each followed by a batch of messages
        target = words_sent + RANDOM_WORDS;
        paused = 1'b0;
        while (words_sent < target)
        begin
            random_config(settings < 8);
            no_idle    = ($urandom_range(0, 3) == 0);
            phase_left = $urandom_range(20, 80);
            while (phase_left != 0)
            begin
                msg_len = $urandom_range(1, 12);
                for (int i = 0; i < msg_len && phase_left != 0; i++)
                begin
                    word = ($urandom_range(0, 15) == 0) ?
                           ($urandom_range(0, 1) ? ONES_32 : 32'd0) : $urandom;
                    // mostly well-formed messages, some continue across a start
                    send_word(word, (i == 0) ? ($urandom_range(0, 9) != 0)
                                             : ($urandom_range(0, 29) == 0));
                    phase_left--;
                end
                // one hold-off mid-stream until every result is back
                if (!paused && words_sent > target - RANDOM_WORDS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
            drain();
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Covered %0d words over %0d settings with %0d register writes",
                 words_sent, settings, reg_writes);
        $display("Checked %0d results, %0d mismatches, %0d results missing",
                 sb.results_seen, sb.mismatches, sb.expected_crc.size());
        if (sb.mismatches == 0 && sb.expected_crc.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
